// ===== rtl/gsd_pkg.sv =====
`default_nettype none

package gsd_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = 8;   // squares used only for magnitudes <= 200
  localparam int unsigned SqW     = 16;
  localparam int unsigned SumW    = 18;
  localparam int unsigned AccW    = 18;
  localparam int unsigned EnergyW = 16;
  localparam int unsigned NumAxes = 3;

  // Thresholds and fixed terms
  localparam logic [SampleW-1:0] WrapLimit = 16'd60000;
  localparam logic [SampleW-1:0] MagLimit  = 16'd200;
  localparam logic [EnergyW-1:0] BigTerm   = 16'd60000;
  localparam logic [SumW-1:0]    TermCap   = 18'd65000;
  localparam logic [AccW-1:0]    AccMax    = 18'd262143;
  localparam logic [EnergyW-1:0] ThreshRst = 16'd10;

  // Load strobes and priming mark shared by the axis lanes
  typedef struct packed {
    logic load_s1;   // input transfer into stage 1
    logic load_s2;   // stage 1 moves to stage 2
    logic prime;     // item at the input is the priming sample
  } gsd_lane_ctl_t;

  // Load strobe and priming mark for the merge stage
  typedef struct packed {
    logic load_out;  // stage 2 moves into the output register
    logic prime;     // item in stage 2 is the priming sample
  } gsd_merge_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/gsd_axis_lane.sv =====
`default_nettype none

module gsd_axis_lane
  import gsd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gsd_lane_ctl_t       ctl,
  input  wire logic [SampleW-1:0]  sample,
  output logic      [SqW-1:0]      sq,
  output logic                     over
);

  logic [SampleW-1:0] mean_r, mean_nxt;
  logic [SampleW-1:0] diff;
  logic [SampleW-1:0] mag;
  logic [MagW-1:0]    mag_r;
  logic               over1_r;
  logic [SqW-1:0]     sq_r;
  logic               over2_r;

  // Halving running mean, loaded outright by the priming sample
  always_comb begin
    if (ctl.prime) begin
      mean_nxt = sample;
    end else begin
      mean_nxt = (mean_r >> 1) + (sample >> 1);
    end
  end

  // Wrapped difference, folded back to its magnitude when above WrapLimit
  assign diff = mean_nxt - sample;
  assign mag  = (diff > WrapLimit) ? (SampleW'(0) - diff) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
    end else if (ctl.load_s1) begin
      mean_r <= mean_nxt;
    end
  end

  // Stage 1: hold magnitude and range flag
  always_ff @(posedge clk) begin
    if (ctl.load_s1) begin
      mag_r   <= mag[MagW-1:0];
      over1_r <= (mag > MagLimit);
    end
  end

  // Stage 2: square the magnitude
  always_ff @(posedge clk) begin
    if (ctl.load_s2) begin
      sq_r    <= SqW'(mag_r * mag_r);
      over2_r <= over1_r;
    end
  end

  assign sq   = sq_r;
  assign over = over2_r;

endmodule

`default_nettype wire

// ===== rtl/gsd_energy_merge.sv =====
`default_nettype none

module gsd_energy_merge
  import gsd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gsd_merge_ctl_t      ctl,
  input  wire logic [SqW-1:0]      sq_x,
  input  wire logic [SqW-1:0]      sq_y,
  input  wire logic [SqW-1:0]      sq_z,
  input  wire logic [NumAxes-1:0]  over,
  input  wire logic                cfg_wr_en,
  input  wire logic [EnergyW-1:0]  cfg_wr_data,
  output logic      [EnergyW-1:0]  energy,
  output logic                     still
);

  logic [EnergyW-1:0] thresh_r;
  logic [AccW-1:0]    acc_r, acc_nxt;
  logic [SumW-1:0]    sum;
  logic [EnergyW-1:0] term;
  logic [AccW:0]      acc_sum;
  logic [EnergyW-1:0] energy_nxt;
  logic [EnergyW-1:0] energy_r;
  logic               still_r;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= ThreshRst;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // Combine lane squares into one energy term
  always_comb begin
    sum = SumW'(sq_x) + SumW'(sq_y) + SumW'(sq_z);
    if (|over) begin
      term = BigTerm;
    end else if (sum > TermCap) begin
      term = TermCap[EnergyW-1:0];
    end else begin
      term = sum[EnergyW-1:0];
    end
  end

  // Leaky accumulator, held across the priming sample
  always_comb begin
    acc_sum = (AccW+1)'(acc_r) - (AccW+1)'(acc_r >> 2) + (AccW+1)'(term);
    if (ctl.prime) begin
      acc_nxt = acc_r;
    end else if (acc_sum > (AccW+1)'(AccMax)) begin
      acc_nxt = AccMax;
    end else begin
      acc_nxt = acc_sum[AccW-1:0];
    end
    energy_nxt = acc_nxt[AccW-1:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.load_out) begin
      acc_r <= acc_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      energy_r <= energy_nxt;
      still_r  <= (energy_nxt <= thresh_r);
    end
  end

  assign energy = energy_r;
  assign still  = still_r;

endmodule

`default_nettype wire

// ===== rtl/gyro_stillness_detector_unit.sv =====
// Input transfer loads stage 1; a result passes stage 2 and the output register before it is valid.
// Throughput: one sample set per cycle; the two lane stages and the output
//   register form one ready chain, so a stalled result blocks input only once
//   all three stages hold a sample set.
// Reset (rst_n, synchronous, active low): pipeline empty, means and energy
//   accumulator zero, next sample primes the means, threshold back to 10.
`default_nettype none

module gyro_stillness_detector_unit
  import gsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,    // [15:0] gyro_x_sample, [31:16] gyro_y_sample,
                                         // [47:32] gyro_z_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,   // [15:0] motion_energy
  output logic             out_tuser,   // [0] is_still
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic           primed_r;
  logic           v1_r, v2_r, vo_r;
  logic           p1_r, p2_r;
  logic           accept, adv1, adv2, out_free, s1_free, s2_free;
  gsd_lane_ctl_t  lane_ctl;
  gsd_merge_ctl_t merge_ctl;
  logic [SqW-1:0] sq_x, sq_y, sq_z;
  logic [NumAxes-1:0] over;
  logic [EnergyW-1:0] energy;
  logic           still;

  // Stage advance chain
  assign out_free  = !vo_r || out_tready;
  assign adv2      = v2_r && out_free;
  assign s2_free   = !v2_r || adv2;
  assign adv1      = v1_r && s2_free;
  assign s1_free   = !v1_r || adv1;
  assign in_tready = s1_free;
  assign accept    = in_tvalid && in_tready;

  // Valid bits and priming marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vo_r     <= 1'b0;
      p1_r     <= 1'b0;
      p2_r     <= 1'b0;
    end else begin
      if (accept) begin
        primed_r <= 1'b1;
        p1_r     <= !primed_r;
      end
      if (adv1) begin
        p2_r <= p1_r;
      end
      v1_r <= accept || (v1_r && !adv1);
      v2_r <= adv1 || (v2_r && !adv2);
      vo_r <= adv2 || (vo_r && !out_tready);
    end
  end

  assign lane_ctl.load_s1   = accept;
  assign lane_ctl.load_s2   = adv1;
  assign lane_ctl.prime     = !primed_r;
  assign merge_ctl.load_out = adv2;
  assign merge_ctl.prime    = p2_r;

  gsd_axis_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (in_tdata[15:0]),
    .sq     (sq_x),
    .over   (over[0])
  );

  gsd_axis_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (in_tdata[31:16]),
    .sq     (sq_y),
    .over   (over[1])
  );

  gsd_axis_lane u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .sample (in_tdata[47:32]),
    .sq     (sq_z),
    .over   (over[2])
  );

  gsd_energy_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (merge_ctl),
    .sq_x        (sq_x),
    .sq_y        (sq_y),
    .sq_z        (sq_z),
    .over        (over),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .energy      (energy),
    .still       (still)
  );

  assign out_tvalid = vo_r;
  assign out_tdata  = energy;
  assign out_tuser  = still;

endmodule

`default_nettype wire

// ===== verif/gsd_stillness_checker.sv =====
`timescale 1ns / 1ps

module gsd_stillness_checker
  import gsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,    // [15:0] gyro_x_sample, [31:16] gyro_y_sample,
                                         // [47:32] gyro_z_sample
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,   // [15:0] motion_energy
  input  wire logic        out_tuser,   // [0] is_still
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output int               mismatch_count,
  output int               pending_results,
  output int               results_checked,
  output int               still_results
);

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic               still;
  } motion_result_t;

  motion_result_t     expected_motion_q[$];
  logic [SampleW-1:0] axis_mean [NumAxes];
  logic [AccW-1:0]    energy_acc;
  logic               primed;
  logic [EnergyW-1:0] still_threshold;

  // Fold a wrapped difference near the top of the range back to its magnitude
  function automatic logic [SampleW-1:0] axis_magnitude(input logic [SampleW-1:0] mean_v,
                                                         input logic [SampleW-1:0] sample_v);
    logic [SampleW-1:0] diff;
    diff = mean_v - sample_v;
    if (diff > WrapLimit) diff = -diff;
    return diff;
  endfunction

  // Any large axis swing gives the fixed big term, else the capped sum of squares
  function automatic int unsigned motion_term(input logic [SampleW-1:0] mx,
                                              input logic [SampleW-1:0] my,
                                              input logic [SampleW-1:0] mz);
    int unsigned sq_sum;
    if (mx > MagLimit || my > MagLimit || mz > MagLimit) return BigTerm;
    sq_sum = mx * mx + my * my + mz * mz;
    return (sq_sum > TermCap) ? TermCap : sq_sum;
  endfunction

  // Advance the means and the leaky accumulator for one sample set
  function automatic motion_result_t predict_motion(input logic [47:0] item);
    logic [SampleW-1:0] sample [NumAxes];
    logic [SampleW-1:0] mag [NumAxes];
    int unsigned        term;
    int unsigned        acc_next;
    motion_result_t     res;
    for (int a = 0; a < NumAxes; a++) sample[a] = item[a*SampleW +: SampleW];
    if (!primed) begin
      // first sample only loads the means
      for (int a = 0; a < NumAxes; a++) axis_mean[a] = sample[a];
      primed = 1'b1;
    end else begin
      for (int a = 0; a < NumAxes; a++) begin
        axis_mean[a] = (axis_mean[a] >> 1) + (sample[a] >> 1);
        mag[a] = axis_magnitude(axis_mean[a], sample[a]);
      end
      term = motion_term(mag[0], mag[1], mag[2]);
      acc_next = energy_acc - (energy_acc >> 2) + term;
      energy_acc = (acc_next > AccMax) ? AccMax : AccW'(acc_next);
    end
    res.energy = energy_acc[AccW-1:2];
    res.still  = (res.energy <= still_threshold);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Track config writes, check result transfers, queue predictions for sample transfers
  always @(posedge clk) begin
    motion_result_t got;
    motion_result_t want;
    if (!rst_n) begin
      expected_motion_q.delete();
      for (int a = 0; a < NumAxes; a++) axis_mean[a] = '0;
      energy_acc      = '0;
      primed          = 1'b0;
      still_threshold = ThreshRst;
      mismatch_count  = 0;
      results_checked = 0;
      still_results   = 0;
    end else begin
      if (cfg_wr_en) still_threshold = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.energy = out_tdata;
        got.still  = out_tuser;
        results_checked++;
        if (got.still) still_results++;
        if (expected_motion_q.size() == 0) begin
          report_mismatch($sformatf("result with none pending: energy %0d, still %0b",
                                    got.energy, got.still));
        end else begin
          want = expected_motion_q.pop_front();
          if (got.energy !== want.energy)
            report_mismatch($sformatf("result %0d motion_energy %0d, want %0d",
                                      results_checked, got.energy, want.energy));
          if (got.still !== want.still)
            report_mismatch($sformatf("result %0d is_still %0b, want %0b (energy %0d)",
                                      results_checked, got.still, want.still, want.energy));
        end
      end
      if (in_tvalid && in_tready) expected_motion_q.push_back(predict_motion(in_tdata));
    end
    pending_results <= expected_motion_q.size();
  end

endmodule

// ===== verif/tb_gyro_stillness_detector_unit.sv =====
`timescale 1ns / 1ps

module tb_gyro_stillness_detector_unit;
  import gsd_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int PhaseItems  = 150;
  localparam int NumPhases   = 6;
  localparam int DrainCycles = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  int mismatch_count;
  int pending_results;
  int results_checked;
  int still_results;
  int cycle_count  = 0;
  int sample_count = 0;

  logic               idle_on = 1'b1;
  logic [SampleW-1:0] drive_mean [NumAxes];
  logic               drive_primed = 1'b0;
  logic [15:0]        phase_threshold [NumPhases];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gyro_stillness_detector_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  gsd_stillness_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .still_results   (still_results)
  );

  // Stall the result side about 30 percent of the time while idling is on
  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 30);
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results);
      $display("tb_gyro_stillness_detector_unit failed");
      $finish;
    end
  end

  // Pick a sample whose updated mean lands target away from it (wrapped);
  // fall back to the mean itself when that difference is out of reach
  function automatic logic [SampleW-1:0] aim_sample(input logic [SampleW-1:0] mean_v,
                                                    input logic [SampleW-1:0] target);
    logic [SampleW:0] half_up;
    half_up = {1'b0, SampleW'((mean_v >> 1) - target)};
    if (half_up > 17'd32768) return mean_v;
    if (half_up == 17'd32768) return 16'hFFFF;
    return {half_up[14:0], 1'b0};
  endfunction

  function automatic logic [SampleW-1:0] jitter(input int amp);
    return SampleW'($urandom_range(2 * amp) - amp);
  endfunction

  // Differences right at the magnitude and wrap boundaries
  function automatic logic [SampleW-1:0] boundary_diff();
    case ($urandom_range(5))
      0:       return 16'd200;
      1:       return 16'd201;
      2:       return SampleW'(-200);
      3:       return SampleW'(-201);
      4:       return 16'd60000;
      default: return 16'd60001;
    endcase
  endfunction

  // Offer one sample set, idling at random first, and hold it until the transfer
  task automatic push_sample(input logic [SampleW-1:0] x, input logic [SampleW-1:0] y,
                             input logic [SampleW-1:0] z);
    logic [SampleW-1:0] sample [NumAxes];
    sample[0] = x;
    sample[1] = y;
    sample[2] = z;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // mirror the running mean so later samples can be aimed
    for (int a = 0; a < NumAxes; a++)
      drive_mean[a] = drive_primed ? (drive_mean[a] >> 1) + (sample[a] >> 1) : sample[a];
    drive_primed = 1'b1;
    sample_count++;
  endtask

  task automatic drive_aimed(input logic [SampleW-1:0] tx, input logic [SampleW-1:0] ty,
                             input logic [SampleW-1:0] tz);
    push_sample(aim_sample(drive_mean[0], tx), aim_sample(drive_mean[1], ty),
                aim_sample(drive_mean[2], tz));
  endtask

  // Drain the pipeline, then write the threshold while the block is idle
  task automatic set_threshold(input logic [15:0] value, input logic idle_next);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    idle_on     <= idle_next;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly settled or jittering runs around the mean, with noise and jumps mixed in
  task automatic run_random_phase(input int budget);
    int                 kind;
    int                 len;
    int                 amp;
    int                 stop;
    logic [SampleW-1:0] held [NumAxes];
    stop = sample_count + budget;
    while (sample_count < stop) begin
      kind = $urandom_range(9);
      len  = (kind < 2) ? $urandom_range(4, 1) : $urandom_range(30, 3);
      case ($urandom_range(3))
        0:       amp = 3;
        1:       amp = 40;
        2:       amp = 130;
        default: amp = 260;
      endcase
      for (int a = 0; a < NumAxes; a++) held[a] = SampleW'($urandom);
      for (int n = 0; n < len && sample_count < stop; n++) begin
        case (kind)
          0, 1:    push_sample(SampleW'($urandom), SampleW'($urandom), SampleW'($urandom));
          2, 3:    drive_aimed('0, '0, '0);
          8:       push_sample(held[0], held[1], held[2]);
          9:       drive_aimed(boundary_diff(), boundary_diff(), boundary_diff());
          default: drive_aimed(jitter(amp), jitter(amp), jitter(amp));
        endcase
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    phase_threshold[0] = 16'd0;
    phase_threshold[1] = 16'd65000;
    phase_threshold[2] = 16'd65535;
    phase_threshold[3] = 16'($urandom_range(3000));
    phase_threshold[4] = 16'($urandom);
    phase_threshold[5] = ThreshRst;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: priming, field extremes, magnitude and wrap boundaries, saturation
    push_sample(16'h0000, 16'h0000, 16'h0000);
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_aimed(16'd0, 16'd0, 16'd0);
    drive_aimed(16'd200, 16'd0, 16'd0);
    drive_aimed(16'd0, 16'd201, 16'd0);
    drive_aimed(16'd0, 16'd0, SampleW'(-200));
    drive_aimed(SampleW'(-201), 16'd0, 16'd0);
    drive_aimed(16'd200, 16'd200, 16'd200);
    drive_aimed(16'd150, 16'd150, 16'd100);
    drive_aimed(16'd60000, 16'd60001, 16'd0);
    drive_aimed(16'd1, SampleW'(-1), 16'd0);
    repeat (4) drive_aimed(16'd0, 16'd0, 16'd0);
    push_sample(16'h5555, 16'hAAAA, 16'h5555);
    push_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    push_sample(16'h0000, 16'hFFFF, 16'h0000);

    // Random phases, one threshold each; the full-rate threshold phase idles nowhere
    for (int p = 0; p < NumPhases; p++) begin
      set_threshold(phase_threshold[p], p != 2);
      run_random_phase(PhaseItems);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("covered %0d sample transfers across %0d threshold settings, %0d results checked",
             sample_count, NumPhases + 1, results_checked);
    $display("%0d results flagged still, %0d mismatches", still_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_gyro_stillness_detector_unit passed");
    end else begin
      $display("tb_gyro_stillness_detector_unit failed");
    end
    $finish;
  end

endmodule
